[hw/rtl/nes_pkg.sv]
// Shared types, codes and defaults for the nearest edge search block.
package nes_pkg;

  localparam int DEF_MAX_NODES  = 1024;
  localparam int DEF_COORD_BITS = 32;

  localparam logic [0:0] CFG_ROOT_X = 1'b0;
  localparam logic [0:0] CFG_ROOT_Y = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REPARENT = 2'd1,
    OP_QUERY    = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [9:0]  target_node;
    logic [9:0]  parent_node;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  new_index;
    logic [31:0] near_x;
    logic [31:0] near_y;
    logic [9:0]  begin_index;
    logic [9:0]  end_index;
    logic [9:0]  clamp_index;
    logic        clamp_valid;
    logic        split_needed;
  } result_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RD1,
    BK_RD2,
    BK_RD3,
    BK_MUL,
    BK_CLS,
    BK_NUM,
    BK_DVI,
    BK_DIV,
    BK_OFS,
    BK_DST,
    BK_CMP,
    BK_FIN
  } bk_state_t;

endpackage

[hw/rtl/nes_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module nes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[hw/rtl/nes_front.sv]
// Command front end: accepts beats, decodes the command and queues them for the back end.
module nes_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     in_command,
  input  logic [31:0]    in_pos_x,
  input  logic [31:0]    in_pos_y,
  input  logic [9:0]     in_target_node,
  input  logic [9:0]     in_parent_node,
  input  logic           pop,
  output logic           head_valid,
  output nes_pkg::item_t head
);
  import nes_pkg::*;

  item_t      q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      item;

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_mem_r[rd_ptr_r];

  always_comb begin
    item.op          = op_t'(in_command);
    item.pos_x       = in_pos_x;
    item.pos_y       = in_pos_y;
    item.target_node = in_target_node;
    item.parent_node = in_parent_node;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop && head_valid) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop && head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end
endmodule

[hw/rtl/nes_back.sv]
// Command back end: node storage, edge scan sequencer and shared multiplier and dividers.
module nes_back #(
  parameter int MAX_NODES  = nes_pkg::DEF_MAX_NODES,
  parameter int COORD_BITS = nes_pkg::DEF_COORD_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  nes_pkg::item_t   head,
  output logic             pop,
  input  logic [31:0]      root_x,
  input  logic [31:0]      root_y,
  output logic             out_strobe,
  output nes_pkg::result_t out_res
);
  import nes_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int IW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNTW = $clog2(MAX_NODES + 1);
  localparam int MOW  = CW + 2;
  localparam int PW   = 2 * MOW;
  localparam int RW   = 2 * CW + 3;
  localparam int NAW  = 3 * CW + 5;
  localparam int DCW  = $clog2(CW + 1);

  bk_state_t state_r, state_nxt;

  logic [CNTW-1:0]       count_r, c_r;
  logic signed [CW-1:0]  root_px_r, root_py_r;
  logic                  out_strobe_r;
  result_t               out_r;
  result_t               idle_res;

  logic signed [CW-1:0]  px_r, py_r, wx_r, wy_r, vx_r, vy_r, nx_r, ny_r, bx_r, by_r;
  logic [IW-1:0]         b_r, ci_r, bb_r, be_r, bc_r;
  logic                  cv_r, sp_r, bv_r, bs_r, found_r;
  logic [2:0]            step_r;
  logic signed [PW-1:0]  prod_r, q_r, s_r;
  logic [PW-1:0]         dist_r, best_r;
  logic [NAW-1:0]        nxa_r, nya_r;
  logic [RW-1:0]         remx_r, remy_r;
  logic [CW-1:0]         lowx_r, lowy_r, quox_r, quoy_r;
  logic [DCW-1:0]        dcnt_r;
  logic                  rd_zero_r;

  logic                  pos_we, par_we;
  logic [IW-1:0]         pos_waddr, pos_raddr, par_waddr, par_raddr;
  logic [2*CW-1:0]       pos_wdata, pos_rd;
  logic [IW-1:0]         par_wdata, par_rd;

  logic signed [MOW-1:0] ma, mb;
  logic signed [CW:0]    ex, ey, dx, dy, ddx, ddy, offx, offy, sumx, sumy;
  logic [CW:0]           ex_mag, ey_mag;
  logic [NAW-1:0]        prod_ext;
  logic [RW-1:0]         tx, ty, qq;
  logic                  gex, gey;
  logic                  q_zero, s_le0, s_ge_q, take, last_edge;

  logic signed [63:0]    hx64, hy64, rx64, ry64, bx64, by64;
  logic signed [CW-1:0]  hx, hy, rx, ry;
  logic [31:0]           cnt32, pn32, tn32, bb32, be32, bc32;
  logic                  add_full, add_bad, rep_bad;

  nes_ram #(.WIDTH(2 * CW), .DEPTH(MAX_NODES)) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(pos_waddr),
    .wdata(pos_wdata),
    .raddr(pos_raddr),
    .rdata(pos_rd)
  );

  nes_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_par_ram (
    .clk  (clk),
    .we   (par_we),
    .waddr(par_waddr),
    .wdata(par_wdata),
    .raddr(par_raddr),
    .rdata(par_rd)
  );

  always_comb begin
    hx64 = 64'($signed(head.pos_x));
    hy64 = 64'($signed(head.pos_y));
    rx64 = 64'($signed(root_x));
    ry64 = 64'($signed(root_y));
    hx   = hx64[CW-1:0];
    hy   = hy64[CW-1:0];
    rx   = rx64[CW-1:0];
    ry   = ry64[CW-1:0];
    cnt32 = 32'(count_r);
    pn32  = 32'(head.parent_node);
    tn32  = 32'(head.target_node);
    add_full = (count_r == CNTW'(MAX_NODES));
    add_bad  = (pn32 >= cnt32);
    rep_bad  = (tn32 >= cnt32) || (pn32 >= cnt32);
  end

  always_comb begin
    idle_res = '0;
    case (head.op)
      OP_ADD: begin
        if (add_full) begin
          idle_res.status = ST_FULL;
        end else if (add_bad) begin
          idle_res.status = ST_UNUSED;
        end else begin
          idle_res.new_index = cnt32[9:0];
        end
      end
      OP_REPARENT: begin
        if (rep_bad) idle_res.status = ST_UNUSED;
      end
      default: ;
    endcase
  end

  always_comb begin
    ex     = {wx_r[CW-1], wx_r} - {vx_r[CW-1], vx_r};
    ey     = {wy_r[CW-1], wy_r} - {vy_r[CW-1], vy_r};
    dx     = {px_r[CW-1], px_r} - {vx_r[CW-1], vx_r};
    dy     = {py_r[CW-1], py_r} - {vy_r[CW-1], vy_r};
    ddx    = {px_r[CW-1], px_r} - {nx_r[CW-1], nx_r};
    ddy    = {py_r[CW-1], py_r} - {ny_r[CW-1], ny_r};
    ex_mag = ex[CW] ? (CW + 1)'(-ex) : ex;
    ey_mag = ey[CW] ? (CW + 1)'(-ey) : ey;
    offx   = ex[CW] ? (CW + 1)'(-$signed({1'b0, quox_r})) : $signed({1'b0, quox_r});
    offy   = ey[CW] ? (CW + 1)'(-$signed({1'b0, quoy_r})) : $signed({1'b0, quoy_r});
    sumx   = {vx_r[CW-1], vx_r} + offx;
    sumy   = {vy_r[CW-1], vy_r} + offy;
    prod_ext = NAW'(prod_r);
    qq     = q_r[RW-1:0];
    tx     = {remx_r[RW-2:0], lowx_r[CW-1]};
    ty     = {remy_r[RW-2:0], lowy_r[CW-1]};
    gex    = (tx >= qq);
    gey    = (ty >= qq);
    q_zero = (q_r == '0);
    s_le0  = s_r[PW-1] || (s_r == '0);
    s_ge_q = (s_r >= q_r);
    take   = !found_r || (dist_r < best_r);
    last_edge = ((c_r + CNTW'(1)) == count_r);
    bx64   = 64'(bx_r);
    by64   = 64'(by_r);
    bb32   = 32'(bb_r);
    be32   = 32'(be_r);
    bc32   = 32'(bc_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head_valid && head.op == OP_QUERY) begin
          state_nxt = (count_r == CNTW'(1)) ? BK_FIN : BK_RD1;
        end
      end
      BK_RD1: state_nxt = BK_RD2;
      BK_RD2: state_nxt = BK_RD3;
      BK_RD3: state_nxt = BK_MUL;
      BK_MUL: if (step_r == 3'd4) state_nxt = BK_CLS;
      BK_CLS: state_nxt = (!q_zero && !s_le0 && !s_ge_q) ? BK_NUM : BK_DST;
      BK_NUM: if (step_r == 3'd4) state_nxt = BK_DVI;
      BK_DVI: state_nxt = BK_DIV;
      BK_DIV: if (dcnt_r == DCW'(1)) state_nxt = BK_OFS;
      BK_OFS: state_nxt = BK_DST;
      BK_DST: if (step_r == 3'd2) state_nxt = BK_CMP;
      BK_CMP: state_nxt = last_edge ? BK_FIN : BK_RD1;
      BK_FIN: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    pos_we    = 1'b0;
    par_we    = 1'b0;
    pos_waddr = count_r[IW-1:0];
    pos_wdata = {hx, hy};
    par_waddr = count_r[IW-1:0];
    par_wdata = pn32[IW-1:0];
    pos_raddr = c_r[IW-1:0];
    par_raddr = c_r[IW-1:0];
    ma        = {ex[CW], ex};
    mb        = {ex[CW], ex};
    case (state_r)
      BK_IDLE: begin
        pop = head_valid;
        if (head_valid) begin
          case (head.op)
            OP_ADD: begin
              pos_we = !add_full && !add_bad;
              par_we = !add_full && !add_bad;
            end
            OP_REPARENT: begin
              par_waddr = tn32[IW-1:0];
              par_we    = !rep_bad && (tn32 != 32'd0);
            end
            default: ;
          endcase
        end
      end
      BK_RD2: pos_raddr = par_rd;
      BK_MUL: begin
        case (step_r)
          3'd1: begin ma = {ey[CW], ey}; mb = {ey[CW], ey}; end
          3'd2: begin ma = {dx[CW], dx}; mb = {ex[CW], ex}; end
          3'd3: begin ma = {dy[CW], dy}; mb = {ey[CW], ey}; end
          default: ;
        endcase
      end
      BK_NUM: begin
        case (step_r)
          3'd0: begin ma = {1'b0, ex_mag}; mb = {1'b0, s_r[CW:0]}; end
          3'd1: begin ma = {1'b0, ex_mag}; mb = {1'b0, s_r[2*CW+1:CW+1]}; end
          3'd2: begin ma = {1'b0, ey_mag}; mb = {1'b0, s_r[CW:0]}; end
          default: begin ma = {1'b0, ey_mag}; mb = {1'b0, s_r[2*CW+1:CW+1]}; end
        endcase
      end
      BK_DST: begin
        if (step_r == 3'd0) begin
          ma = {ddx[CW], ddx};
          mb = {ddx[CW], ddx};
        end else begin
          ma = {ddy[CW], ddy};
          mb = {ddy[CW], ddy};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      count_r      <= CNTW'(1);
      root_px_r    <= '0;
      root_py_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == BK_FIN) || (state_r == BK_IDLE && head_valid &&
                      head.op != OP_QUERY);
      if (state_r == BK_IDLE && head_valid) begin
        if (head.op == OP_ADD && !add_full && !add_bad) begin
          count_r <= count_r + CNTW'(1);
        end
        if (head.op == OP_CLEAR) begin
          count_r   <= CNTW'(1);
          root_px_r <= rx;
          root_py_r <= ry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r    <= ma * mb;
    rd_zero_r <= (pos_raddr == '0);
    case (state_r)
      BK_IDLE: begin
        out_r   <= idle_res;
        px_r    <= hx;
        py_r    <= hy;
        bx_r    <= root_px_r;
        by_r    <= root_py_r;
        bb_r    <= '0;
        be_r    <= '0;
        bc_r    <= '0;
        bv_r    <= 1'b1;
        bs_r    <= 1'b0;
        found_r <= 1'b0;
        c_r     <= CNTW'(1);
      end
      BK_RD2: begin
        wx_r <= pos_rd[2*CW-1:CW];
        wy_r <= pos_rd[CW-1:0];
        b_r  <= par_rd;
      end
      BK_RD3: begin
        vx_r   <= rd_zero_r ? root_px_r : pos_rd[2*CW-1:CW];
        vy_r   <= rd_zero_r ? root_py_r : pos_rd[CW-1:0];
        step_r <= 3'd0;
      end
      BK_MUL: begin
        step_r <= step_r + 3'd1;
        case (step_r)
          3'd1: q_r <= prod_r;
          3'd2: q_r <= q_r + prod_r;
          3'd3: s_r <= prod_r;
          3'd4: s_r <= s_r + prod_r;
          default: ;
        endcase
      end
      BK_CLS: begin
        step_r <= 3'd0;
        cv_r   <= 1'b1;
        sp_r   <= 1'b0;
        if (q_zero || s_le0) begin
          nx_r <= vx_r;
          ny_r <= vy_r;
          ci_r <= b_r;
        end else begin
          nx_r <= wx_r;
          ny_r <= wy_r;
          ci_r <= c_r[IW-1:0];
        end
      end
      BK_NUM: begin
        step_r <= step_r + 3'd1;
        case (step_r)
          3'd1: nxa_r <= prod_ext;
          3'd2: nxa_r <= nxa_r + (prod_ext << (CW + 1));
          3'd3: nya_r <= prod_ext;
          3'd4: nya_r <= nya_r + (prod_ext << (CW + 1));
          default: ;
        endcase
      end
      BK_DVI: begin
        remx_r <= nxa_r[CW+RW-1:CW];
        remy_r <= nya_r[CW+RW-1:CW];
        lowx_r <= nxa_r[CW-1:0];
        lowy_r <= nya_r[CW-1:0];
        quox_r <= '0;
        quoy_r <= '0;
        dcnt_r <= DCW'(CW);
      end
      BK_DIV: begin
        remx_r <= gex ? (tx - qq) : tx;
        remy_r <= gey ? (ty - qq) : ty;
        lowx_r <= {lowx_r[CW-2:0], 1'b0};
        lowy_r <= {lowy_r[CW-2:0], 1'b0};
        quox_r <= {quox_r[CW-2:0], gex};
        quoy_r <= {quoy_r[CW-2:0], gey};
        dcnt_r <= dcnt_r - DCW'(1);
      end
      BK_OFS: begin
        nx_r   <= sumx[CW-1:0];
        ny_r   <= sumy[CW-1:0];
        ci_r   <= '0;
        cv_r   <= 1'b0;
        sp_r   <= 1'b1;
        step_r <= 3'd0;
      end
      BK_DST: begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd1) begin
          dist_r <= prod_r;
        end else if (step_r == 3'd2) begin
          dist_r <= dist_r + prod_r;
        end
      end
      BK_CMP: begin
        if (take) begin
          found_r <= 1'b1;
          best_r  <= dist_r;
          bx_r    <= nx_r;
          by_r    <= ny_r;
          bb_r    <= b_r;
          be_r    <= c_r[IW-1:0];
          bc_r    <= ci_r;
          bv_r    <= cv_r;
          bs_r    <= sp_r;
        end
        c_r <= c_r + CNTW'(1);
      end
      BK_FIN: begin
        out_r.status       <= ST_OK;
        out_r.new_index    <= '0;
        out_r.near_x       <= bx64[31:0];
        out_r.near_y       <= by64[31:0];
        out_r.begin_index  <= bb32[9:0];
        out_r.end_index    <= be32[9:0];
        out_r.clamp_index  <= bc32[9:0];
        out_r.clamp_valid  <= bv_r;
        out_r.split_needed <= bs_r;
      end
      default: ;
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_r;
endmodule

[hw/rtl/rrt_nearest_edge_search.sv]
// Top level of the tree nearest edge search block: configuration, front end and back end.
//
//  channel  | ports                                | handshake
//  ---------+--------------------------------------+-----------------------------
//  command  | start, busy, in_*                    | beat taken when start && !busy
//  result   | out_strobe, out_*                    | one cycle per beat, no stall
//  config   | cfg_we, cfg_index, cfg_wdata         | written when cfg_we is high
//
// Add, reparent and clear are answered from the back end idle state; the command queue
// and the result strobe are registered. A query scans each edge from node 1 up to the
// last node and runs the restoring dividers only when the projection falls inside it.
// Reset leaves one node, the root at the origin; clear reloads it from the root registers.
// A two beat command queue keeps start open while the back end works, until it fills; results never stall.
module rrt_nearest_edge_search #(
  parameter int MAX_NODES  = nes_pkg::DEF_MAX_NODES,
  parameter int COORD_BITS = nes_pkg::DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [9:0]  in_target_node,
  input  logic [9:0]  in_parent_node,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [9:0]  out_new_index,
  output logic [31:0] out_near_x,
  output logic [31:0] out_near_y,
  output logic [9:0]  out_begin_index,
  output logic [9:0]  out_end_index,
  output logic [9:0]  out_clamp_index,
  output logic        out_clamp_valid,
  output logic        out_split_needed,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import nes_pkg::*;

  logic [31:0] root_x_r, root_y_r;
  logic        head_valid, pop;
  item_t       head;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_x_r <= '0;
      root_y_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROOT_X) begin
        root_x_r <= cfg_wdata;
      end
      if (cfg_index == CFG_ROOT_Y) begin
        root_y_r <= cfg_wdata;
      end
    end
  end

  nes_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_target_node(in_target_node),
    .in_parent_node(in_parent_node),
    .pop           (pop),
    .head_valid    (head_valid),
    .head          (head)
  );

  nes_back #(
    .MAX_NODES (MAX_NODES),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .root_x    (root_x_r),
    .root_y    (root_y_r),
    .out_strobe(out_strobe),
    .out_res   (res)
  );

  assign out_status       = res.status;
  assign out_new_index    = res.new_index;
  assign out_near_x       = res.near_x;
  assign out_near_y       = res.near_y;
  assign out_begin_index  = res.begin_index;
  assign out_end_index    = res.end_index;
  assign out_clamp_index  = res.clamp_index;
  assign out_clamp_valid  = res.clamp_valid;
  assign out_split_needed = res.split_needed;
endmodule
